@@ src/ucld_pkg.sv @@
// Shared types, constants and prefix tables for the UART command line decoder.
`timescale 1ns / 1ps
`default_nettype none

package ucld_pkg;

    // Line buffer size and the width of the line position counter.
    localparam int LINE_BUF_BYTES = 128;
    localparam int POS_W          = $clog2(LINE_BUF_BYTES);

    // Character codes used by the framing and the parser.
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Largest magnitude the number parser keeps; it marks an out of range speed.
    localparam logic [6:0] MAG_SAT = 7'd101;

    // Result action codes.
    typedef enum logic [1:0] {
        ACT_PUMP  = 2'd0,
        ACT_VALVE = 2'd1,
        ACT_PIN9  = 2'd2
    } action_t;

    // One result item.
    typedef struct packed {
        action_t    action;
        logic [6:0] pump_speed;
        logic       switch_on;
    } result_t;

    // Expected byte of "@PUMP:" at a position below six.
    function automatic logic [7:0] pump_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h40;
            3'd1:    c = 8'h50;
            3'd2:    c = 8'h55;
            3'd3:    c = 8'h4D;
            3'd4:    c = 8'h50;
            3'd5:    c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected byte of "@VALVE:" at a position below seven.
    function automatic logic [7:0] valve_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h40;
            3'd1:    c = 8'h56;
            3'd2:    c = 8'h41;
            3'd3:    c = 8'h4C;
            3'd4:    c = 8'h56;
            3'd5:    c = 8'h45;
            3'd6:    c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected byte of "@OUT:" at a position below five.
    function automatic logic [7:0] out_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h40;
            3'd1:    c = 8'h4F;
            3'd2:    c = 8'h55;
            3'd3:    c = 8'h54;
            3'd4:    c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/ucld_parse.sv @@
// Line framing and on-the-fly command parser with its per-line state registers.
`timescale 1ns / 1ps
`default_nettype none

module ucld_parse
    import ucld_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       byte_take,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    output result_t         res_data
);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_STOP   = 2'd2
    } phase_t;

    localparam int CAND_PUMP  = 0;
    localparam int CAND_VALVE = 1;
    localparam int CAND_OUT   = 2;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_BUF_BYTES - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       cand_reg, cand_next;
    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [6:0]       mag_reg, mag_next;
    logic             valve_one_reg, valve_one_next;
    logic             pin_nine_reg, pin_nine_next;
    logic             level_one_reg, level_one_next;

    logic [POS_W-1:0] pos_eff;
    logic             line_full;
    logic             is_digit;
    logic             is_space;
    logic [3:0]       digit_val;
    logic [10:0]      mag_acc;

    // Character classes and the decimal value of a digit byte.
    always_comb begin
        is_digit  = (rx_byte inside {[8'h30:8'h39]});
        is_space  = (rx_byte inside {8'h20, [8'h09:8'h0D]});
        digit_val = 4'(rx_byte - CHAR_ZERO);
    end

    // Position of this byte: an '@' always starts the line over.
    always_comb begin
        pos_eff   = (rx_byte == CHAR_AT) ? '0 : pos_reg;
        line_full = (pos_eff >= POS_LAST);
    end

    // Decode the byte against the line state, cleared first at position zero.
    always_comb begin
        logic [6:0] mag_base;
        mag_base = (pos_eff == '0) ? 7'd0 : mag_reg;
        if (pos_eff == '0) begin
            cand_next      = 3'b111;
            phase_next     = PH_SKIP;
            neg_next       = 1'b0;
            valve_one_next = 1'b0;
            pin_nine_next  = 1'b0;
            level_one_next = 1'b0;
        end else begin
            cand_next      = cand_reg;
            phase_next     = phase_reg;
            neg_next       = neg_reg;
            valve_one_next = valve_one_reg;
            pin_nine_next  = pin_nine_reg;
            level_one_next = level_one_reg;
        end
        mag_next = mag_base;
        mag_acc  = {1'b0, mag_base, 3'b000} + {3'b000, mag_base, 1'b0} + {7'd0, digit_val};

        // Prefix matching drops a command as soon as one byte differs.
        if (pos_eff < POS_W'(6) && rx_byte != pump_char(pos_eff[2:0])) begin
            cand_next[CAND_PUMP] = 1'b0;
        end
        if (pos_eff < POS_W'(7) && rx_byte != valve_char(pos_eff[2:0])) begin
            cand_next[CAND_VALVE] = 1'b0;
        end
        if (pos_eff < POS_W'(5) && rx_byte != out_char(pos_eff[2:0])) begin
            cand_next[CAND_OUT] = 1'b0;
        end

        // Number parsing from position six on.
        if (pos_eff >= POS_W'(6)) begin
            case (phase_next)
                PH_SKIP: begin
                    if (is_space) begin
                        phase_next = PH_SKIP;
                    end else if (rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS) begin
                        neg_next   = (rx_byte == CHAR_MINUS);
                        phase_next = PH_DIGITS;
                    end else if (is_digit) begin
                        phase_next = PH_DIGITS;
                        mag_next   = (mag_acc > 11'(MAG_SAT)) ? MAG_SAT : mag_acc[6:0];
                    end else begin
                        phase_next = PH_STOP;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        mag_next = (mag_acc > 11'(MAG_SAT)) ? MAG_SAT : mag_acc[6:0];
                    end else begin
                        phase_next = PH_STOP;
                    end
                end
                default: begin
                    phase_next = PH_STOP;
                end
            endcase
        end

        // Fixed character positions of the valve and output commands.
        if (pos_eff == POS_W'(5)) begin
            pin_nine_next = (rx_byte == CHAR_NINE);
        end
        if (pos_eff == POS_W'(7)) begin
            valve_one_next = (rx_byte == CHAR_ONE);
            level_one_next = (rx_byte == CHAR_ONE);
        end

        // Next position: a full line drops the byte, a line end restarts.
        if (line_full || rx_byte == CHAR_LF) begin
            pos_next = '0;
        end else begin
            pos_next = pos_eff + POS_W'(1);
        end
    end

    // Command selection on the line end byte.
    always_comb begin
        res_valid           = 1'b0;
        res_data.action     = ACT_PUMP;
        res_data.pump_speed = 7'd0;
        res_data.switch_on  = 1'b0;
        if (!line_full && rx_byte == CHAR_LF) begin
            if (cand_next[CAND_PUMP]) begin
                res_valid           = (mag_next < MAG_SAT) && !(neg_next && mag_next != 7'd0);
                res_data.action     = ACT_PUMP;
                res_data.pump_speed = mag_next;
                res_data.switch_on  = (mag_next != 7'd0);
            end else if (cand_next[CAND_VALVE]) begin
                res_valid          = 1'b1;
                res_data.action    = ACT_VALVE;
                res_data.switch_on = valve_one_next;
            end else if (cand_next[CAND_OUT] && pin_nine_next) begin
                res_valid          = 1'b1;
                res_data.action    = ACT_PIN9;
                res_data.switch_on = level_one_next;
            end
        end
    end

    // State registers; a dropped byte only returns the position to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            cand_reg      <= 3'b111;
            phase_reg     <= PH_SKIP;
            neg_reg       <= 1'b0;
            mag_reg       <= 7'd0;
            valve_one_reg <= 1'b0;
            pin_nine_reg  <= 1'b0;
            level_one_reg <= 1'b0;
        end else if (byte_take) begin
            pos_reg <= pos_next;
            if (!line_full) begin
                cand_reg      <= cand_next;
                phase_reg     <= phase_next;
                neg_reg       <= neg_next;
                mag_reg       <= mag_next;
                valve_one_reg <= valve_one_next;
                pin_nine_reg  <= pin_nine_next;
                level_one_reg <= level_one_next;
            end
        end
    end

`ifndef ASSERT_OFF
    // A line end always returns the position to the start of a line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_take && rx_byte == CHAR_LF |=> pos_reg == '0)
        else $error("position not cleared after line end");

    // The stored magnitude never passes the saturation value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mag_reg <= MAG_SAT)
        else $error("number magnitude above saturation");

    // A result only comes from a line end byte that was not dropped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> rx_byte == CHAR_LF && !line_full)
        else $error("result without a line end");

    // A pump result always carries an in-range speed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_data.action == ACT_PUMP |-> res_data.pump_speed <= 7'd100)
        else $error("pump speed out of range");
`endif

endmodule

`default_nettype wire

@@ src/ucld_out_buf.sv @@
// Two-entry result buffer: output register plus a skid register.
`timescale 1ns / 1ps
`default_nettype none

module ucld_out_buf
    import ucld_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         space_ok,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign space_ok  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Refill the output register from the skid entry or from a new transfer.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_data_next = push_data;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef ASSERT_OFF
    // The skid entry is only ever behind a full output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // No push arrives while both entries are full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("push into a full buffer");

    // A waiting skid entry moves up when the output is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop && skid_valid_reg |=> out_valid_reg && out_data_reg == $past(skid_data_reg))
        else $error("skid entry lost on output transfer");
`endif

endmodule

`default_nettype wire

@@ src/uart_command_line_decoder_top.sv @@
// Top level of the UART command line decoder.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received UART byte per transfer on the s_ channel and frames the
// bytes into lines: '@' restarts a line, '\n' ends it, and a line longer than
// LINE_BUF_BYTES-1 bytes drops the byte and starts over. Each line is decoded
// as it streams in as @PUMP:n, @VALVE:c or @OUT:9?c, and a line end that
// matches a command gives one result transfer on the m_ channel (action,
// pump_speed, switch_on). Every byte is decoded in the cycle it is accepted
// and the parser state registers update at that edge, so one byte is taken
// per clock cycle while s_ready is high. The result lands in an output
// register backed by a skid register; s_ready drops only when both hold
// results that the sink has not taken, and m_valid shows the output register.
module uart_command_line_decoder_top
    import ucld_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_action,
    output logic [6:0]      m_pump_speed,
    output logic            m_switch_on
);

    logic    byte_take;
    logic    res_valid;
    result_t res_data;
    result_t out_data;

    assign byte_take = s_valid && s_ready;

    // Framing and command decode of each accepted byte.
    ucld_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_take (byte_take),
        .rx_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Result register with skid entry.
    ucld_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (byte_take && res_valid),
        .push_data (res_data),
        .space_ok  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_action     = out_data.action;
    assign m_pump_speed = out_data.pump_speed;
    assign m_switch_on  = out_data.switch_on;

endmodule

`default_nettype wire

@@ sim/tb_uart_command_line_decoder_top.sv @@
// Testbench for the UART command line decoder: directed command lines, then random traffic.
`timescale 1ns / 1ps

module tb_uart_command_line_decoder_top;
    import ucld_pkg::*;

    localparam int RANDOM_BYTES     = 620;
    localparam int QUIET_TAIL_BYTES = 200;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 20;
    localparam int REPORT_LIMIT     = 10;
    localparam int RUN_LIMIT_NS     = 3_000_000;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Bit positions of the command prefixes that are still matching.
    localparam int LIVE_PUMP  = 0;
    localparam int LIVE_VALVE = 1;
    localparam int LIVE_OUT   = 2;

    typedef enum logic [1:0] {
        NUM_SKIP,
        NUM_DIGITS,
        NUM_STOP
    } num_phase_e;

    // One directed line, with an optional hand-written expectation for its line end.
    typedef struct {
        string      text;
        int         pad_n;
        logic [7:0] pad_char;
        bit         typed;
        bit         hit;
        result_t    res;
    } line_case_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_ready   = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [1:0] m_action;
    logic [6:0] m_pump_speed;
    logic       m_switch_on;

    // Command decoder state kept by the testbench.
    int unsigned line_pos    = 0;
    logic [2:0]  prefix_live = 3'b111;
    num_phase_e  num_phase   = NUM_SKIP;
    bit          num_neg     = 1'b0;
    int unsigned num_mag     = 0;
    bit          valve_one   = 1'b0;
    bit          pin_nine    = 1'b0;
    bit          level_one   = 1'b0;
    string       pump_tag    = "@PUMP:";
    string       valve_tag   = "@VALVE:";
    string       out_tag     = "@OUT:";

    logic [7:0] blank_set [5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};

    result_t    pending_results [$];
    line_case_t directed_rows [$];
    logic [7:0] line_buf [$];

    int idle_pct      = 0;
    bit sink_hold_req = 1'b0;
    int fault_count   = 0;
    int bytes_sent    = 0;
    int lines_sent    = 0;
    int results_seen  = 0;
    int pump_seen     = 0;
    int valve_seen    = 0;
    int pin_seen      = 0;

    uart_command_line_decoder_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_action     (m_action),
        .m_pump_speed (m_pump_speed),
        .m_switch_on  (m_switch_on)
    );

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic result_t make_result(input action_t a, input int speed, input bit on);
        result_t r;
        r.action     = a;
        r.pump_speed = 7'(speed);
        r.switch_on  = on;
        return r;
    endfunction

    // Advances the decoder state by one byte; returns 1 when the byte ends a command line.
    function automatic bit decode_step(input logic [7:0] c, output result_t r);
        int unsigned p;
        bit          is_digit;
        bit          is_blank;
        bit          sign_taken;
        r          = '0;
        sign_taken = 1'b0;
        if (c == CHAR_AT) begin
            line_pos = 0;
        end
        // A full line drops the byte and starts over.
        if (line_pos >= LINE_BUF_BYTES - 1) begin
            line_pos = 0;
            return 1'b0;
        end
        p = line_pos;
        if (p == 0) begin
            prefix_live = 3'b111;
            num_phase   = NUM_SKIP;
            num_neg     = 1'b0;
            num_mag     = 0;
            valve_one   = 1'b0;
            pin_nine    = 1'b0;
            level_one   = 1'b0;
        end
        if (p < 6 && c != pump_tag[p]) prefix_live[LIVE_PUMP] = 1'b0;
        if (p < 7 && c != valve_tag[p]) prefix_live[LIVE_VALVE] = 1'b0;
        if (p < 5 && c != out_tag[p]) prefix_live[LIVE_OUT] = 1'b0;

        // The pump number is read from position six on, much like atoi.
        if (p >= 6) begin
            is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
            is_blank = (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR));
            if (num_phase == NUM_SKIP && !is_blank) begin
                if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                    num_neg    = (c == CHAR_MINUS);
                    num_phase  = NUM_DIGITS;
                    sign_taken = 1'b1;
                end else begin
                    num_phase = is_digit ? NUM_DIGITS : NUM_STOP;
                end
            end
            if (num_phase == NUM_DIGITS && !sign_taken) begin
                if (is_digit) begin
                    num_mag = num_mag * 10 + int'(c - CHAR_ZERO);
                    if (num_mag > MAG_SAT) num_mag = MAG_SAT;
                end else begin
                    num_phase = NUM_STOP;
                end
            end
        end
        if (p == 5) pin_nine = (c == CHAR_NINE);
        if (p == 7) begin
            valve_one = (c == CHAR_ONE);
            level_one = (c == CHAR_ONE);
        end
        line_pos = p + 1;
        if (c != CHAR_LF) return 1'b0;
        line_pos = 0;

        // The line end picks the first command whose prefix still matches.
        if (prefix_live[LIVE_PUMP]) begin
            if (num_mag >= MAG_SAT) return 1'b0;
            if (num_neg && num_mag != 0) return 1'b0;
            r = make_result(ACT_PUMP, int'(num_mag), num_mag != 0);
            return 1'b1;
        end
        if (prefix_live[LIVE_VALVE]) begin
            r = make_result(ACT_VALVE, 0, valve_one);
            return 1'b1;
        end
        if (prefix_live[LIVE_OUT] && pin_nine) begin
            r = make_result(ACT_PIN9, 0, level_one);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_AT || b == CHAR_LF);
        return b;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic add_row(input string text, input int pad_n, input logic [7:0] pad_char,
                           input bit typed, input bit hit, input result_t res);
        line_case_t row;
        row.text     = text;
        row.pad_n    = pad_n;
        row.pad_char = pad_char;
        row.typed    = typed;
        row.hit      = hit;
        row.res      = res;
        directed_rows.push_back(row);
    endtask

    // Offers one byte at the falling edge and holds it until the transfer.
    task automatic send_byte(input logic [7:0] b, input bit predict_it);
        result_t r;
        bit      hit;
        int      gap;
        hit = decode_step(b, r);
        if (hit && predict_it) pending_results.push_back(r);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Sends line_buf; a typed line takes its line end expectation from the table.
    task automatic send_line(input bit typed, input bit hit, input result_t res);
        for (int i = 0; i < line_buf.size(); i++) begin
            if (typed && i == line_buf.size() - 1) begin
                if (hit) pending_results.push_back(res);
                send_byte(line_buf[i], 1'b0);
            end else begin
                send_byte(line_buf[i], 1'b1);
            end
        end
        lines_sent++;
    endtask

    // Drops valid and waits until every predicted result has been taken.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Builds a mostly well-formed command line with random content, or noise.
    task automatic make_random_line();
        int kind;
        int k;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            add_text("@PUMP:");
            repeat ($urandom_range(0, 3)) line_buf.push_back(blank_set[$urandom_range(0, 4)]);
            k = $urandom_range(0, 5);
            if (k == 0) line_buf.push_back(CHAR_PLUS);
            if (k == 1) line_buf.push_back(CHAR_MINUS);
            case ($urandom_range(0, 3))
                0: add_text($sformatf("%0d", $urandom_range(0, 100)));
                1: repeat ($urandom_range(0, 4))
                       line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                2: add_text($sformatf("%0d", $urandom_range(95, 130)));
                default: add_text($sformatf("%0d", $urandom_range(0, 20)));
            endcase
            if ($urandom_range(0, 3) == 0) line_buf.push_back(plain_byte());
            line_buf.push_back(CHAR_LF);
        end else if (kind < 53) begin
            add_text("@VALVE:");
            line_buf.push_back($urandom_range(0, 1) ? CHAR_ONE : plain_byte());
            repeat ($urandom_range(0, 2)) line_buf.push_back(plain_byte());
            line_buf.push_back(CHAR_LF);
        end else if (kind < 73) begin
            add_text("@OUT:");
            line_buf.push_back($urandom_range(0, 3) != 0 ? CHAR_NINE : plain_byte());
            line_buf.push_back(plain_byte());
            line_buf.push_back($urandom_range(0, 1) ? CHAR_ONE : plain_byte());
            repeat ($urandom_range(0, 2)) line_buf.push_back(plain_byte());
            line_buf.push_back(CHAR_LF);
        end else if (kind < 98) begin
            repeat ($urandom_range(1, 16)) line_buf.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) line_buf.push_back(CHAR_LF);
        end else begin
            repeat ($urandom_range(120, 140)) line_buf.push_back(plain_byte());
            line_buf.push_back(CHAR_LF);
        end

        // Break about one command line in five: a stray byte or an early line end.
        if (kind < 73 && $urandom_range(0, 4) == 0) begin
            k = $urandom_range(0, line_buf.size() - 2);
            if ($urandom_range(0, 1)) begin
                line_buf[k] = 8'($urandom_range(0, 255));
            end else begin
                while (line_buf.size() > k + 1) void'(line_buf.pop_back());
                line_buf.push_back(CHAR_LF);
            end
        end
    endtask

    // Result side: random stalls, and one long hold-off on request.
    initial begin : result_sink
        int n;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                m_ready <= 1'b0;
                for (n = 0; n < SINK_HOLD_CYCLES; n++) @(negedge aclk);
                sink_hold_req = 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compares every result transfer with the oldest prediction.
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got.action     = action_t'(m_action);
            got.pump_speed = m_pump_speed;
            got.switch_on  = m_switch_on;
            results_seen++;
            if (pending_results.size() == 0) begin
                if (fault_count < REPORT_LIMIT)
                    $display("%0t: unexpected result action %0d speed %0d on %0b",
                             $realtime, m_action, m_pump_speed, m_switch_on);
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                case (want.action)
                    ACT_PUMP:  pump_seen++;
                    ACT_VALVE: valve_seen++;
                    default:   pin_seen++;
                endcase
                if (got.action !== want.action || got.pump_speed !== want.pump_speed ||
                    got.switch_on !== want.switch_on) begin
                    if (fault_count < REPORT_LIMIT)
                        $display({"%0t: mismatch: expected action %0d speed %0d on %0b, ",
                                  "got action %0d speed %0d on %0b"},
                                 $realtime, want.action, want.pump_speed, want.switch_on,
                                 m_action, m_pump_speed, m_switch_on);
                    fault_count++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still pending.", pending_results.size());
        $display("FAIL uart_command_line_decoder_top");
        $finish;
    end

    initial begin : stimulus
        int random_bytes;
        int seg_lines;

        // Directed lines: each command, its edge values and the framing corner cases.
        add_row("@PUMP:100\n", 0, 8'h00, 1, 1, make_result(ACT_PUMP, 100, 1'b1));
        add_row("@PUMP:0\n", 0, 8'h00, 1, 1, make_result(ACT_PUMP, 0, 1'b0));
        add_row("@PUMP:101\n", 0, 8'h00, 1, 0, '0);
        add_row("@PUMP:-7\n", 0, 8'h00, 1, 0, '0);
        add_row("@PUMP:-0\n", 0, 8'h00, 1, 1, make_result(ACT_PUMP, 0, 1'b0));
        add_row("@PUMP:99999\n", 0, 8'h00, 1, 0, '0);
        add_row("@PUMP: \t\v\f\r+42x\n", 0, 8'h00, 0, 0, '0);
        add_row("@PUMP:\n", 0, 8'h00, 0, 0, '0);
        add_row("@PUMP:+-5\n", 0, 8'h00, 0, 0, '0);
        add_row("@VALVE:1\n", 0, 8'h00, 1, 1, make_result(ACT_VALVE, 0, 1'b1));
        add_row("@VALVE:0\n", 0, 8'h00, 1, 1, make_result(ACT_VALVE, 0, 1'b0));
        add_row("@VALVE\n", 0, 8'h00, 0, 0, '0);
        add_row("@OUT:9x1\n", 0, 8'h00, 1, 1, make_result(ACT_PIN9, 0, 1'b1));
        add_row("@OUT:9?0\n", 0, 8'h00, 0, 0, '0);
        add_row("@OUT:9\n", 0, 8'h00, 0, 0, '0);
        add_row("@OUT:8?1\n", 0, 8'h00, 1, 0, '0);
        add_row("xx@VALVE:1\n", 0, 8'h00, 0, 0, '0);
        // Full line: the byte after the last free position is dropped.
        add_row("\n", 127, "z", 0, 0, '0);
        add_row("q@PUMP:5\n", 127, " ", 0, 0, '0);
        add_row("VALVE:1\n", 128, "x", 0, 0, '0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_pct = 15;
        foreach (directed_rows[r]) begin
            line_buf.delete();
            repeat (directed_rows[r].pad_n) line_buf.push_back(directed_rows[r].pad_char);
            add_text(directed_rows[r].text);
            send_line(directed_rows[r].typed, directed_rows[r].hit, directed_rows[r].res);
        end
        wait_drained();

        // Back-pressure: the sink holds off while short command lines keep coming.
        idle_pct      = 0;
        sink_hold_req = 1'b1;
        for (int i = 0; i < 24; i++) begin
            line_buf.delete();
            add_text(i % 2 ? "@OUT:9?1\n" : "@VALVE:1\n");
            send_line(1'b0, 1'b0, '0);
        end
        wait_drained();

        // Random traffic in segments of varying idle density, quiet at the tail.
        random_bytes = 0;
        seg_lines    = 0;
        while (random_bytes < RANDOM_BYTES) begin
            if (RANDOM_BYTES - random_bytes < QUIET_TAIL_BYTES) begin
                idle_pct = 0;
            end else if (seg_lines % 12 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 8;
                    default: idle_pct = 25;
                endcase
            end
            make_random_line();
            random_bytes += line_buf.size();
            send_line(1'b0, 1'b0, '0);
            seg_lines++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d lines; checked %0d results (pump %0d, valve %0d, %s",
                 bytes_sent, lines_sent, results_seen, pump_seen, valve_seen,
                 $sformatf("pin nine %0d).", pin_seen));
        $display({"Covered full lines, bad prefixes, saturated and signed speeds, ",
                  "and a long sink stall."});
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("PASS uart_command_line_decoder_top");
        end else begin
            $display("%0d faults, %0d results missing.", fault_count, pending_results.size());
            $display("FAIL uart_command_line_decoder_top");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/ucld_pkg.sv
src/ucld_parse.sv
src/ucld_out_buf.sv
src/uart_command_line_decoder_top.sv
sim/tb_uart_command_line_decoder_top.sv
